// File: hw/rtl/vpf_pkg.sv
`timescale 1ns / 1ps
package vpf_pkg;

    localparam int FRAME_LEN = 40;
    localparam int CRC_SPAN  = 36;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_ONES = 32'hffffffff;

    // magic, version, type, pad
    localparam logic [31:0] FRAME_MAGIC = {8'h44, 8'h41, 8'h49, 8'h42};
    localparam logic [7:0]  FRAME_VER   = 8'h01;
    localparam logic [7:0]  FRAME_TYPE  = 8'h01;

    localparam logic [5:0]  POS_CRC_FIRST = 6'(CRC_SPAN);
    localparam logic [5:0]  POS_LAST      = 6'(FRAME_LEN - 1);

    localparam logic [2:0]  REG_FRAME_ENABLE = 3'h0;

    typedef struct packed {
        logic [31:0] seq;
        logic [63:0] stamp;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] yaw_rate;
    } t_frame_rec;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc_in, input logic [7:0] b);
        logic [31:0] acc;
        acc = acc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic logic [7:0] frame_byte(input t_frame_rec rec, input logic [5:0] pos,
                                              input logic [31:0] crc);
        logic [319:0] frame;
        frame = {FRAME_MAGIC, FRAME_VER, FRAME_TYPE, 16'h0000, rec.seq, rec.stamp,
                 rec.vel_x, rec.vel_y, rec.vel_z, rec.yaw_rate, crc ^ CRC_ONES};
        return frame[9'(POS_LAST - pos) * 9'd8 +: 8];
    endfunction

endpackage

// File: hw/rtl/vpf_front.sv
`timescale 1ns / 1ps
module vpf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_enable,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command_valid,
    input  logic [63:0]         i_stamp_us,
    input  logic [31:0]         i_vel_x_bits,
    input  logic [31:0]         i_vel_y_bits,
    input  logic [31:0]         i_vel_z_bits,
    input  logic [31:0]         i_yaw_rate_bits,
    input  logic                i_q_full,
    output logic                o_push,
    output vpf_pkg::t_frame_rec o_rec
);
    import vpf_pkg::*;

    logic [31:0] r_seq;
    logic [31:0] n_seq;

    assign o_stall = i_q_full;
    // disabled commands are taken and dropped
    assign o_push  = i_valid && !i_q_full && i_enable;

    always_comb begin
        o_rec.seq      = r_seq;
        o_rec.stamp    = i_stamp_us;
        o_rec.vel_x    = i_command_valid ? i_vel_x_bits    : 32'h0;
        o_rec.vel_y    = i_command_valid ? i_vel_y_bits    : 32'h0;
        o_rec.vel_z    = i_command_valid ? i_vel_z_bits    : 32'h0;
        o_rec.yaw_rate = i_command_valid ? i_yaw_rate_bits : 32'h0;
        n_seq          = o_push ? r_seq + 32'd1 : r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 32'h0;
        end else begin
            r_seq <= n_seq;
        end
    end

endmodule

// File: hw/rtl/vpf_queue.sv
`timescale 1ns / 1ps
module vpf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vpf_pkg::t_frame_rec i_rec,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output vpf_pkg::t_frame_rec o_rec
);
    import vpf_pkg::*;

    t_frame_rec r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: hw/rtl/vpf_back.sv
`timescale 1ns / 1ps
module vpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  vpf_pkg::t_frame_rec i_q_rec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_frame_byte,
    output logic                o_frame_last
);
    import vpf_pkg::*;

    t_frame_rec  r_rec;
    logic        r_busy;
    logic [5:0]  r_pos;
    logic [31:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic        space;
    logic        step;
    logic        done;
    logic [7:0]  cur_byte;

    assign space    = !r_out_valid || !i_stall;
    assign step     = r_busy && space;
    assign done     = step && (r_pos == POS_LAST);
    // next frame is loaded as the last byte of the current one goes out
    assign o_pop    = i_q_valid && (!r_busy || done);
    assign cur_byte = frame_byte(r_rec, r_pos, r_crc);

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_q_rec;
        end
        if (step) begin
            r_byte <= cur_byte;
            r_last <= (r_pos == POS_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= 6'd0;
            r_crc       <= CRC_ONES;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= 6'd0;
                r_crc  <= CRC_ONES;
            end else if (step) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos < POS_CRC_FIRST) begin
                    r_crc <= crc_byte(r_crc, cur_byte);
                end
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// File: hw/rtl/velocity_packet_framer_crc32_unit.sv
`timescale 1ns / 1ps
// velocity command framer with crc-32 trailer
// input channel: i_valid / o_stall with one command per word (valid flag,
//   64-bit microsecond stamp, four float32 bit patterns)
// output channel: o_valid / i_stall, one frame byte per word, o_frame_last on
//   the final crc byte; each enabled command yields a 40-word frame
// apb port: register 0 at address 0 is frame_enable; with it clear, commands
//   are taken and dropped and the sequence number holds
// first-byte path: if the serializer is idle, a taken command is written to
//   the queue, popped into the serializer and its first byte registered out
// throughput: one byte per cycle while i_stall is low, set by the byte
//   serializer; the crc advances one byte per cycle alongside it
// a 2-entry command queue lets commands be taken while a frame streams out
// stalling the receiver freezes the output word and the serializer; the
//   queue fills and then o_stall rises
// reset: sequence number to zero, frame_enable to zero, queue and output empty
module velocity_packet_framer_crc32_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command_valid,
    input  logic [63:0] i_stamp_us,
    input  logic [31:0] i_vel_x_bits,
    input  logic [31:0] i_vel_y_bits,
    input  logic [31:0] i_vel_z_bits,
    input  logic [31:0] i_yaw_rate_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last
);
    import vpf_pkg::*;

    logic       r_enable;
    logic       q_full;
    logic       q_push;
    logic       q_valid;
    logic       q_pop;
    t_frame_rec push_rec;
    t_frame_rec head_rec;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FRAME_ENABLE) ? {31'h0, r_enable} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_FRAME_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    vpf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enable        (r_enable),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command_valid (i_command_valid),
        .i_stamp_us      (i_stamp_us),
        .i_vel_x_bits    (i_vel_x_bits),
        .i_vel_y_bits    (i_vel_y_bits),
        .i_vel_z_bits    (i_vel_z_bits),
        .i_yaw_rate_bits (i_yaw_rate_bits),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_rec           (push_rec)
    );

    vpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    vpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_rec      (head_rec),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule
